### rtl/core/lbp_3x3_replicate_stream_assert.svh
// assertion macros for the lbp 3x3 stream checker
`ifndef LBP_3X3_REPLICATE_STREAM_ASSERT_SVH
`define LBP_3X3_REPLICATE_STREAM_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LBP3R_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lbp3r: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define LBP3R_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lbp3r: next-cycle check failed");

`endif

### rtl/core/lbp3r_pkg.sv
// types and constants shared by the lbp 3x3 stream block
package lbp3r_pkg;

	localparam int PIX_W          = 8;
	localparam int CODE_W         = 8;
	localparam int FRAME_WIDTH_W  = 12;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_INDEX_W    = 1;
	// row count reaches height + 1 while the last row drains
	localparam int ROW_W          = 14;

	localparam int FRAME_WIDTH_RESET  = 640;
	localparam int FRAME_HEIGHT_RESET = 480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} reg_idx_t;

	// window positions: rows top to bottom, columns oldest (left) to newest (right)
	localparam logic [1:0] WIN_TOP   = 2'd0;
	localparam logic [1:0] WIN_MID   = 2'd1;
	localparam logic [1:0] WIN_BOT   = 2'd2;
	localparam logic [1:0] WIN_LEFT  = 2'd0;
	localparam logic [1:0] WIN_CTR   = 2'd1;
	localparam logic [1:0] WIN_RIGHT = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic first_col;
		logic last_col;
	} edge_t;

endpackage

### rtl/core/lbp3r_in_if.sv
// pixel input channel
interface lbp3r_in_if;
	logic                       valid;
	logic                       ready;
	logic [lbp3r_pkg::PIX_W-1:0] pixel;
	logic                       flush;

	modport source (output valid, output pixel, output flush, input ready);
	modport sink (input valid, input pixel, input flush, output ready);
	modport monitor (input valid, input pixel, input flush, input ready);
endinterface

### rtl/core/lbp3r_out_if.sv
// pattern code output channel
interface lbp3r_out_if;
	logic                        valid;
	logic                        ready;
	logic [lbp3r_pkg::CODE_W-1:0] pattern_code;
	logic                        frame_last;

	modport source (output valid, output pattern_code, output frame_last, input ready);
	modport sink (input valid, input pattern_code, input frame_last, output ready);
	modport monitor (input valid, input pattern_code, input frame_last, input ready);
endinterface

### rtl/core/lbp3r_ram.sv
// generic single-write, single-read ram with registered read data
module lbp3r_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/lbp3r_code.sv
// lbp code from a 3x3 window with edge replication
module lbp3r_code (
	input  lbp3r_pkg::win_t               win,
	input  lbp3r_pkg::edge_t              edges,
	output logic [lbp3r_pkg::CODE_W-1:0]  code
);
	logic [1:0]      top_r, bot_r, left_c, right_c;
	lbp3r_pkg::pix_t ctr;

	always_comb begin
		// missing neighbors fall back to the centre row or column
		top_r   = edges.first_row ? lbp3r_pkg::WIN_MID : lbp3r_pkg::WIN_TOP;
		bot_r   = edges.last_row  ? lbp3r_pkg::WIN_MID : lbp3r_pkg::WIN_BOT;
		left_c  = edges.first_col ? lbp3r_pkg::WIN_CTR : lbp3r_pkg::WIN_LEFT;
		right_c = edges.last_col  ? lbp3r_pkg::WIN_CTR : lbp3r_pkg::WIN_RIGHT;
		ctr     = win[lbp3r_pkg::WIN_MID][lbp3r_pkg::WIN_CTR];

		code[7] = win[top_r][left_c] > ctr;
		code[6] = win[top_r][lbp3r_pkg::WIN_CTR] > ctr;
		code[5] = win[top_r][right_c] > ctr;
		code[4] = win[lbp3r_pkg::WIN_MID][right_c] > ctr;
		code[3] = win[bot_r][right_c] > ctr;
		code[2] = win[bot_r][lbp3r_pkg::WIN_CTR] > ctr;
		code[1] = win[bot_r][left_c] > ctr;
		code[0] = win[lbp3r_pkg::WIN_MID][left_c] > ctr;
	end
endmodule

### rtl/core/lbp_3x3_replicate_stream.sv
// top level of the streaming 3x3 local binary pattern block
//
// pixels: grey pixels in raster order, valid/ready; flush items carry value 0
// codes: one lbp code per pixel, valid/ready, frame_last on the frame's final code
// cfg_we/cfg_index/cfg_data: register writes (frame width, frame height), idle only;
//   any write restarts the stream at the start of a frame
// the code of a pixel leaves with the item width+1 positions later; the first
//   width+1 items of a frame give no code, so a frame needs width+1 drain items
// one item is accepted per cycle while pixels.ready is high; a code reaches the output
//   after the item that completes it, through the window stage and the output register
// two line buffers in ram hold the previous two rows; their read is issued ahead at
//   the next column, with a bypass when the address repeats
// reset: position at frame start, width 640, height 480, window cleared,
//   line buffer contents undefined until written
// receiver stall: the output register holds its code and one more code can
//   wait in the window stage; after that pixels.ready drops
module lbp_3x3_replicate_stream #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lbp3r_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lbp3r_pkg::CFG_DATA_W-1:0]    cfg_data,
	lbp3r_in_if.sink                            pixels,
	lbp3r_out_if.source                         codes
);
	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int ROW_W   = lbp3r_pkg::ROW_W;
	localparam int RESET_W = (lbp3r_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : lbp3r_pkg::FRAME_WIDTH_RESET;
	localparam logic [CW-1:0] WM1_RESET = CW'(RESET_W - 1);
	localparam logic [lbp3r_pkg::FRAME_HEIGHT_W-1:0] HM1_RESET =
		lbp3r_pkg::FRAME_HEIGHT_W'(lbp3r_pkg::FRAME_HEIGHT_RESET - 1);

	// configuration
	logic [CW-1:0]                       wm1_q, wm1_new;
	logic [lbp3r_pkg::FRAME_HEIGHT_W-1:0] hm1_q, hm1_new, h_raw;
	logic [31:0]                         w_raw;

	// position and window
	logic [CW-1:0]    col_q, col_nxt, c_out;
	logic [ROW_W-1:0] row_q, row_nxt, r_out, hm1_ext;
	logic             accept, has_k, over, last, emit, col_wrap;
	lbp3r_pkg::pix_t  v, top, mid, up_rdata, mid_rdata, up_byp_q, mid_byp_q;
	logic             hit_q;
	lbp3r_pkg::win_t  window_q;
	lbp3r_pkg::edge_t edge_new;

	// window stage and output register
	logic                          valid_s1, move;
	lbp3r_pkg::edge_t              edge_s1;
	logic [lbp3r_pkg::CODE_W-1:0]  code;
	logic [lbp3r_pkg::CODE_W-1:0]  code_q;
	logic                          last_q, out_valid_q;

	always_comb begin
		w_raw = 32'(cfg_data[lbp3r_pkg::FRAME_WIDTH_W-1:0]);
		h_raw = cfg_data[lbp3r_pkg::FRAME_HEIGHT_W-1:0];
		priority if (w_raw == 32'd0) begin
			wm1_new = '0;
		end else if (w_raw > 32'(MAX_WIDTH)) begin
			wm1_new = CW'(MAX_WIDTH - 1);
		end else begin
			wm1_new = CW'(w_raw - 32'd1);
		end
		hm1_new = (h_raw == '0) ? '0 : h_raw - lbp3r_pkg::FRAME_HEIGHT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= WM1_RESET;
			hm1_q <= HM1_RESET;
		end else if (cfg_we) begin
			unique case (lbp3r_pkg::reg_idx_t'(cfg_index))
				lbp3r_pkg::REG_FRAME_WIDTH:  wm1_q <= wm1_new;
				lbp3r_pkg::REG_FRAME_HEIGHT: hm1_q <= hm1_new;
			endcase
		end
	end

	assign move         = valid_s1 && (!out_valid_q || codes.ready);
	assign pixels.ready = !valid_s1 || move;
	assign accept       = pixels.valid && pixels.ready;
	assign v            = pixels.flush ? '0 : pixels.pixel;

	// position of the pixel whose code this item completes
	always_comb begin
		hm1_ext  = ROW_W'(hm1_q);
		col_wrap = (col_q == wm1_q);
		has_k    = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
		c_out    = (col_q == '0) ? wm1_q : col_q - CW'(1);
		r_out    = (col_q == '0) ? row_q - ROW_W'(2) : row_q - ROW_W'(1);
		over     = has_k && (r_out > hm1_ext);
		last     = has_k && !over && (r_out == hm1_ext) && (c_out == wm1_q);
		emit     = has_k && !over;

		edge_new.first_row = (r_out == '0);
		edge_new.last_row  = (r_out == hm1_ext);
		edge_new.first_col = (c_out == '0);
		edge_new.last_col  = (c_out == wm1_q);

		priority if (cfg_we || (accept && (over || last))) begin
			col_nxt = '0;
			row_nxt = '0;
		end else if (accept && col_wrap) begin
			col_nxt = '0;
			row_nxt = row_q + ROW_W'(1);
		end else if (accept) begin
			col_nxt = col_q + CW'(1);
			row_nxt = row_q;
		end else begin
			col_nxt = col_q;
			row_nxt = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			hit_q <= 1'b0;
		end else begin
			col_q <= col_nxt;
			row_q <= row_nxt;
			// ram read of the address just written returns stale data
			hit_q <= accept && (col_nxt == col_q);
		end
	end

	always_ff @(posedge clk) begin
		up_byp_q  <= mid;
		mid_byp_q <= v;
	end

	assign top = hit_q ? up_byp_q  : up_rdata;
	assign mid = hit_q ? mid_byp_q : mid_rdata;

	lbp3r_ram #(
		.WIDTH(lbp3r_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_upper_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (mid),
		.raddr (col_nxt),
		.rdata (up_rdata)
	);

	lbp3r_ram #(
		.WIDTH(lbp3r_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_middle_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (v),
		.raddr (col_nxt),
		.rdata (mid_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i][lbp3r_pkg::WIN_LEFT] <= window_q[i][lbp3r_pkg::WIN_CTR];
				window_q[i][lbp3r_pkg::WIN_CTR]  <= window_q[i][lbp3r_pkg::WIN_RIGHT];
			end
			window_q[lbp3r_pkg::WIN_TOP][lbp3r_pkg::WIN_RIGHT] <= top;
			window_q[lbp3r_pkg::WIN_MID][lbp3r_pkg::WIN_RIGHT] <= mid;
			window_q[lbp3r_pkg::WIN_BOT][lbp3r_pkg::WIN_RIGHT] <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edge_s1 <= edge_new;
		end
	end

	lbp3r_code u_code (
		.win   (window_q),
		.edges (edge_s1),
		.code  (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			code_q <= code;
			last_q <= edge_s1.last_row && edge_s1.last_col;
		end
	end

	assign codes.valid        = out_valid_q;
	assign codes.pattern_code = code_q;
	assign codes.frame_last   = last_q;
endmodule

### rtl/core/lbp3r_chk.sv
// port checker for the lbp 3x3 stream block, bound to the top level
`include "lbp_3x3_replicate_stream_assert.svh"

module lbp3r_chk (
	input logic         clk,
	input logic         arst_n,
	lbp3r_in_if.sink    pixels,
	lbp3r_out_if.source codes
);
	// a waiting code keeps its value
	`LBP3R_ASSERT_NXT(a_code_hold, codes.valid && !codes.ready,
		codes.valid && $stable(codes.pattern_code) && $stable(codes.frame_last))

	// with the output register empty, the window stage always drains
	`LBP3R_ASSERT_IMP(a_ready_when_out_empty, !codes.valid, pixels.ready)

	// a receiver that takes codes never stalls the input
	`LBP3R_ASSERT_IMP(a_ready_follows_out, codes.ready, pixels.ready)

	// a fresh code goes out after the item that completed it passes the window stage and output register
	`LBP3R_ASSERT_IMP(a_code_after_item, $rose(codes.valid),
		$past(pixels.valid && pixels.ready, 2))
endmodule

bind lbp_3x3_replicate_stream lbp3r_chk u_lbp3r_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.pixels (pixels),
	.codes  (codes)
);

### bench/lbp_3x3_replicate_stream_tb.sv
// self-checking testbench for the streaming 3x3 local binary pattern block
`timescale 1ns / 100ps

module lbp_3x3_replicate_stream_tb;

	localparam int LINE_DEPTH    = 2048;
	localparam int RANDOM_ITEMS  = 650;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 400;
	localparam int QUIET_LIMIT   = 3000;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		lbp3r_pkg::pix_t pixel;
		logic            flush;
	} pixel_item_t;

	typedef struct packed {
		logic [lbp3r_pkg::CODE_W-1:0] code;
		logic                         last;
	} lbp_code_t;

	typedef enum {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;
	typedef enum {MIX_UNIFORM, MIX_EXTREME, MIX_TIES} pix_mix_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_we;
	logic [lbp3r_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lbp3r_pkg::CFG_DATA_W-1:0]  cfg_data;

	lbp3r_in_if  pixels_if ();
	lbp3r_out_if codes_if ();

	lbp_3x3_replicate_stream #(
		.MAX_WIDTH(LINE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels_if.sink),
		.codes    (codes_if.source)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// shadow of the block: two stored rows, the 3x3 window, the input position
	lbp3r_pkg::pix_t                      older_row [LINE_DEPTH];
	lbp3r_pkg::pix_t                      newer_row [LINE_DEPTH];
	lbp3r_pkg::pix_t                      nbhd [3][3];
	int unsigned                          col_pos;
	int unsigned                          row_pos;
	logic [lbp3r_pkg::FRAME_WIDTH_W-1:0]  width_reg;
	logic [lbp3r_pkg::FRAME_HEIGHT_W-1:0] height_reg;

	pixel_item_t pixel_q [$];
	lbp_code_t   expected_codes [$];
	int unsigned errors;
	int unsigned queued_items;
	int unsigned quiet_cycles;
	int unsigned hold_reqs;

	function automatic int unsigned frame_w();
		if (width_reg == 0)
			return 1;
		if (width_reg > LINE_DEPTH)
			return LINE_DEPTH;
		return width_reg;
	endfunction

	function automatic int unsigned frame_h();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic void lbp_clear();
		int i;
		for (i = 0; i < LINE_DEPTH; i++) begin
			older_row[i] = '0;
			newer_row[i] = '0;
		end
		for (i = 0; i < 9; i++)
			nbhd[i / 3][i % 3] = '0;
		col_pos = 0;
		row_pos = 0;
		width_reg = lbp3r_pkg::FRAME_WIDTH_W'(lbp3r_pkg::FRAME_WIDTH_RESET);
		height_reg = lbp3r_pkg::FRAME_HEIGHT_W'(lbp3r_pkg::FRAME_HEIGHT_RESET);
	endfunction

	function automatic void lbp_set_reg(input lbp3r_pkg::reg_idx_t idx,
			input logic [lbp3r_pkg::CFG_DATA_W-1:0] val);
		if (idx == lbp3r_pkg::REG_FRAME_WIDTH)
			width_reg = val[lbp3r_pkg::FRAME_WIDTH_W-1:0];
		else
			height_reg = val[lbp3r_pkg::FRAME_HEIGHT_W-1:0];
		col_pos = 0;
		row_pos = 0;
	endfunction

	// one accepted item: update the shadow, return 1 when it releases a code
	function automatic bit lbp_advance(input lbp3r_pkg::pix_t pixel, input logic flush,
			output lbp_code_t res);
		int unsigned     w, h, x, r, c, i;
		longint unsigned k, m, total;
		lbp3r_pkg::pix_t v, top, mid, ctr;
		logic [1:0]      tr, br, lc, rc;
		w = frame_w();
		h = frame_h();
		v = flush ? '0 : pixel;
		x = (col_pos >= w) ? 0 : col_pos;
		res = '0;
		top = older_row[x];
		mid = newer_row[x];
		older_row[x] = mid;
		newer_row[x] = v;
		for (i = 0; i < 3; i++) begin
			nbhd[i][lbp3r_pkg::WIN_LEFT] = nbhd[i][lbp3r_pkg::WIN_CTR];
			nbhd[i][lbp3r_pkg::WIN_CTR] = nbhd[i][lbp3r_pkg::WIN_RIGHT];
		end
		nbhd[lbp3r_pkg::WIN_TOP][lbp3r_pkg::WIN_RIGHT] = top;
		nbhd[lbp3r_pkg::WIN_MID][lbp3r_pkg::WIN_RIGHT] = mid;
		nbhd[lbp3r_pkg::WIN_BOT][lbp3r_pkg::WIN_RIGHT] = v;
		k = longint'(row_pos) * w + x;
		x++;
		if (x >= w) begin
			x = 0;
			row_pos++;
		end
		col_pos = x;
		if (k < w + 1)
			return 0;
		m = k - w - 1;
		total = longint'(w) * h;
		if (m >= total) begin
			col_pos = 0;
			row_pos = 0;
			return 0;
		end
		r = 32'(m / w);
		c = 32'(m % w);
		ctr = nbhd[lbp3r_pkg::WIN_MID][lbp3r_pkg::WIN_CTR];
		// replicate the edge: a missing neighbour row or column falls back to the centre one
		tr = (r == 0) ? lbp3r_pkg::WIN_MID : lbp3r_pkg::WIN_TOP;
		br = (r == h - 1) ? lbp3r_pkg::WIN_MID : lbp3r_pkg::WIN_BOT;
		lc = (c == 0) ? lbp3r_pkg::WIN_CTR : lbp3r_pkg::WIN_LEFT;
		rc = (c == w - 1) ? lbp3r_pkg::WIN_CTR : lbp3r_pkg::WIN_RIGHT;
		res.code = {nbhd[tr][lc] > ctr, nbhd[tr][lbp3r_pkg::WIN_CTR] > ctr,
			nbhd[tr][rc] > ctr, nbhd[lbp3r_pkg::WIN_MID][rc] > ctr,
			nbhd[br][rc] > ctr, nbhd[br][lbp3r_pkg::WIN_CTR] > ctr,
			nbhd[br][lc] > ctr, nbhd[lbp3r_pkg::WIN_MID][lc] > ctr};
		res.last = (m == total - 1);
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
		end
		return 1;
	endfunction

	function automatic lbp3r_pkg::pix_t draw_pixel(input pix_mix_t mix);
		case (mix)
			MIX_EXTREME: begin
				case ($urandom_range(3))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd254;
					default: return 8'd255;
				endcase
			end
			MIX_TIES: return 8'd100 + 8'($urandom_range(2));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic push_item(input lbp3r_pkg::pix_t pixel, input logic flush);
		pixel_item_t item;
		item.pixel = pixel;
		item.flush = flush;
		pixel_q = {pixel_q, item};
		queued_items++;
	endtask

	// whole frame then width+1 drain items, some of them carrying a pixel
	task automatic push_frame(input pix_mix_t mix);
		int unsigned w, h, i;
		w = frame_w();
		h = frame_h();
		for (i = 0; i < w * h; i++)
			push_item(draw_pixel(mix), $urandom_range(99) < 3);
		for (i = 0; i <= w; i++)
			push_item(draw_pixel(mix), $urandom_range(7) != 0);
	endtask

	task automatic settle();
		while (pixel_q.size() != 0 || pixels_if.valid || expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input bit set_w, input logic [lbp3r_pkg::CFG_DATA_W-1:0] wdata,
			input bit set_h, input logic [lbp3r_pkg::CFG_DATA_W-1:0] hdata);
		settle();
		if (set_w) begin
			cfg_we <= 1'b1;
			cfg_index <= lbp3r_pkg::REG_FRAME_WIDTH;
			cfg_data <= wdata;
			lbp_set_reg(lbp3r_pkg::REG_FRAME_WIDTH, wdata);
			@(posedge clk);
		end
		if (set_h) begin
			cfg_we <= 1'b1;
			cfg_index <= lbp3r_pkg::REG_FRAME_HEIGHT;
			cfg_data <= hdata;
			lbp_set_reg(lbp3r_pkg::REG_FRAME_HEIGHT, hdata);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// sender: bursts of items with gaps between them
	pixel_item_t cur_item;
	lbp_code_t   next_code;
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixels_if.valid && pixels_if.ready) begin
				if (lbp_advance(pixels_if.pixel, pixels_if.flush, next_code))
					expected_codes = {expected_codes, next_code};
			end
			if (!pixels_if.valid || pixels_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					pixels_if.valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					cur_item = pixel_q.pop_front();
					pixels_if.valid <= 1'b1;
					pixels_if.pixel <= cur_item.pixel;
					pixels_if.flush <= cur_item.flush;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300) :
							$urandom_range(1, 40);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					pixels_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus long holds on request
	rx_mode_t    rx_mode;
	int unsigned rx_mode_left;
	int unsigned rx_cycle;
	int unsigned hold_done;
	int unsigned hold_left;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_done != hold_reqs) begin
				hold_done = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(3));
				rx_mode_left = $urandom_range(64, 400);
			end else begin
				rx_mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				codes_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  codes_if.ready <= 1'b1;
					RX_LIGHT:   codes_if.ready <= ($urandom_range(3) != 0);
					RX_HEAVY:   codes_if.ready <= ($urandom_range(3) == 0);
					default:    codes_if.ready <= (rx_cycle % 5 != 2);
				endcase
			end
		end
	end

	// checker: each code against the oldest expectation
	lbp_code_t want;

	always @(posedge clk) begin
		if (arst_n && codes_if.valid && codes_if.ready) begin
			if (expected_codes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("code %02h last %0b with nothing expected",
						codes_if.pattern_code, codes_if.frame_last);
			end else begin
				want = expected_codes.pop_front();
				if (codes_if.pattern_code !== want.code || codes_if.frame_last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch: expected code %02h last %0b, got code %02h last %0b",
							want.code, want.last, codes_if.pattern_code, codes_if.frame_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixels_if.valid && pixels_if.ready) || (codes_if.valid && codes_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL lbp_3x3_replicate_stream");
				$finish;
			end
		end
	end

	initial begin
		int unsigned                      phase, i, queued_mark, random_items, sel;
		bit                               force_both, big;
		logic [lbp3r_pkg::CFG_DATA_W-1:0] wdata, hdata;
		cfg_we = 1'b0;
		cfg_index = lbp3r_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		pixels_if.valid = 1'b0;
		pixels_if.pixel = '0;
		pixels_if.flush = 1'b0;
		codes_if.ready = 1'b0;
		errors = 0;
		queued_items = 0;
		quiet_cycles = 0;
		hold_reqs = 0;
		hold_done = 0;
		hold_left = 0;
		burst_left = 0;
		gap_left = 0;
		rx_mode_left = 0;
		rx_cycle = 0;
		lbp_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// default geometry after reset: enough of a row for the first codes
		for (i = 0; i < 650; i++)
			push_item(draw_pixel(MIX_UNIFORM), 1'b0);

		// small frame with extremes, flush inside the frame and a pixel during drain
		configure(1'b1, 13'd3, 1'b1, 13'd2);
		push_item(8'd255, 1'b0);
		push_item(8'd0, 1'b0);
		push_item(8'd255, 1'b0);
		push_item(8'd0, 1'b0);
		push_item(8'd255, 1'b0);
		push_item(8'd77, 1'b1);
		push_item(8'd12, 1'b1);
		push_item(8'd0, 1'b1);
		push_item(8'd200, 1'b0);
		push_item(8'd255, 1'b1);
		// zero width and zero height act as one
		configure(1'b1, 13'd0, 1'b1, 13'd0);
		push_item(8'd77, 1'b0);
		push_item(8'd3, 1'b1);
		push_item(8'd9, 1'b0);
		// single column, three rows
		configure(1'b0, 13'd0, 1'b1, 13'd3);
		push_item(8'd5, 1'b0);
		push_item(8'd5, 1'b0);
		push_item(8'd9, 1'b0);
		push_item(8'd0, 1'b1);
		push_item(8'd0, 1'b1);
		// flat frame gives all-zero codes
		configure(1'b1, 13'd2, 1'b1, 13'd2);
		for (i = 0; i < 4; i++)
			push_item(8'd100, 1'b0);
		for (i = 0; i < 3; i++)
			push_item(8'd100, 1'b1);

		phase = 0;
		random_items = 0;
		force_both = 1'b1;
		while (random_items < RANDOM_ITEMS || phase < 12) begin
			queued_mark = queued_items;
			big = 1'b0;
			case (phase)
				2: begin
					// full line depth, start of the first row only
					big = 1'b1;
					configure(1'b1, 13'd2048, 1'b1, 13'd1);
					for (i = 0; i < 40; i++)
						push_item(draw_pixel(MIX_UNIFORM), 1'b0);
				end
				5: begin
					// width beyond the line depth, stopped partway
					big = 1'b1;
					configure(1'b1, 13'd4095, 1'b1, 13'd0);
					for (i = 0; i < 40; i++)
						push_item(draw_pixel(MIX_UNIFORM), 1'b0);
				end
				8: begin
					big = 1'b1;
					configure(1'b1, 13'd1, 1'b1, 13'd8191);
					for (i = 0; i < 100; i++)
						push_item(draw_pixel(MIX_EXTREME), $urandom_range(19) == 0);
				end
				11: begin
					big = 1'b1;
					configure(1'b1, 13'd3, 1'b1, 13'd4096);
					for (i = 0; i < 60; i++)
						push_item(draw_pixel(MIX_TIES), 1'b0);
				end
				1, 7: begin
					// several frames, then a long receiver hold while items keep coming
					configure(1'b1, 13'd8, 1'b1, 13'd6);
					for (i = 0; i < 3; i++)
						push_frame(pix_mix_t'($urandom_range(2)));
					while (expected_codes.size() < 3 && pixel_q.size() != 0)
						@(posedge clk);
					hold_reqs++;
				end
				default: begin
					wdata = {1'($urandom_range(1)),
						($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 12))};
					sel = $urandom_range(9);
					if (sel == 0) begin
						hdata = '0;
					end else if (sel == 1) begin
						hdata = 13'($urandom_range(40, 150));
						wdata[lbp3r_pkg::FRAME_WIDTH_W-1:0] = 12'($urandom_range(1, 3));
						force_both = 1'b1;
					end else begin
						hdata = 13'($urandom_range(1, 6));
					end
					if (force_both)
						configure(1'b1, wdata, 1'b1, hdata);
					else begin
						case ($urandom_range(5))
							0: configure(1'b1, wdata, 1'b0, hdata);
							1: configure(1'b0, wdata, 1'b1, hdata);
							default: configure(1'b1, wdata, 1'b1, hdata);
						endcase
					end
					force_both = 1'b0;
					for (i = $urandom_range(1, 2); i > 0; i--) begin
						case ($urandom_range(19))
							0: begin
								// broken frame: cut short, the next write restarts it
								repeat ($urandom_range(frame_w() * frame_h()))
									push_item(draw_pixel(MIX_UNIFORM), $urandom_range(9) == 0);
							end
							1: begin
								repeat ($urandom_range(1, 4))
									push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
								push_frame(pix_mix_t'($urandom_range(2)));
							end
							default: push_frame(pix_mix_t'($urandom_range(2)));
						endcase
					end
				end
			endcase
			if (big)
				force_both = 1'b1;
			else
				random_items += queued_items - queued_mark;
			phase++;
		end

		settle();
		if (errors == 0 && expected_codes.size() == 0)
			$display("PASS lbp_3x3_replicate_stream");
		else
			$display("FAIL lbp_3x3_replicate_stream");
		$finish;
	end

endmodule
